// File: hw/rtl/mavg_pkg.sv
// Shared constant for the moving-average sample filter.
`timescale 1ns / 1ps
`default_nettype none

package mavg_pkg;

  // Width of the window length register write data
  localparam int CFG_W = 8;

endpackage

`default_nettype wire

// File: hw/rtl/mavg_if.sv
// Valid/ready channel interfaces for samples, averages and window writes.
`timescale 1ns / 1ps
`default_nettype none

interface mavg_sample_if #(
  parameter int W = 12
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface mavg_avg_if #(
  parameter int W = 12
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink (input valid, input average, output ready);
endinterface

interface mavg_cfg_if
  import mavg_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] window_length;

  modport source (output valid, output window_length, input ready);
  modport sink (input valid, input window_length, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mavg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mavg_ram #(
  parameter int  WIDTH = 12,
  parameter int  DEPTH = 128,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/mavg_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module mavg_div #(
  parameter int  DIV_W = 20,
  parameter int  DEN_W = 8,
  localparam int CNT_W = $clog2(DIV_W + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [DEN_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [DIV_W-1:0] quotient_o,
  output logic      [DEN_W-1:0] remainder_o
);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             fits;

  // Shift in the next dividend bit and trial-subtract the divisor
  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_q};
    fits   = ~diff[DEN_W+1];
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Quotient and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], fits};
      rem_q <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// File: hw/rtl/moving_average_sample_filter_unit.sv
// Pass-through (window 0): the sample is registered as the result, then loaded into the
// output register. Otherwise the path runs through the ring read and the bit-serial divider.
// A pointer wrap after the window shrank runs the divider once more, for the pointer modulo.
// A new sample waits only until the last result is in the output register.
// Reset: window to WINDOW_DEFAULT (at most WINDOW_MAX), pointer and sum to zero; ring
// entries read as zero via per-entry valid flags until written, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module moving_average_sample_filter_unit
  import mavg_pkg::*;
#(
  parameter int WINDOW_MAX     = 128,
  parameter int WINDOW_DEFAULT = 64,
  parameter int SAMPLE_BITS    = 12
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mavg_sample_if.sink sample_ch_i,
  mavg_avg_if.source  average_ch_o,
  mavg_cfg_if.sink    window_ch_i
);

  localparam int PTR_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int WIN_W   = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_MAX);
  localparam int DIV_W   = SUM_W + 1;
  localparam int WIN_RST = (WINDOW_DEFAULT > WINDOW_MAX) ? WINDOW_MAX : WINDOW_DEFAULT;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PMOD,
    ST_MEAN,
    ST_HOLD
  } st_e;

  st_e                    state_q;
  logic [WIN_W-1:0]       window_q;
  logic [PTR_W-1:0]       ptr_q;
  logic [SUM_W-1:0]       sum_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [SAMPLE_BITS-1:0] res_q;
  logic [WINDOW_MAX-1:0]  ring_vld_q;
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_avg_q;

  logic                   in_xfer;
  logic                   out_free;
  logic [SAMPLE_BITS-1:0] ring_rdata;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [SUM_W-1:0]       sum_new;
  logic [WIN_W-1:0]       ptr_inc;
  logic                   ptr_wrap_div;
  logic [DIV_W-1:0]       half_win;
  logic                   div_start;
  logic [DIV_W-1:0]       div_dividend;
  logic                   div_done;
  logic [DIV_W-1:0]       div_quo;
  logic [WIN_W-1:0]       div_rem;
  logic [SAMPLE_BITS-1:0] mean_sat;

  // Window register, saturated to the maximum
  assign window_ch_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WIN_W'(WIN_RST);
    end else if (window_ch_i.valid) begin
      if (int'(window_ch_i.window_length) > WINDOW_MAX) begin
        window_q <= WIN_W'(WINDOW_MAX);
      end else begin
        window_q <= WIN_W'(window_ch_i.window_length);
      end
    end
  end

  assign sample_ch_i.ready  = (state_q == ST_IDLE);
  assign in_xfer            = sample_ch_i.valid && sample_ch_i.ready;
  assign out_free           = !out_valid_q || average_ch_o.ready;
  assign average_ch_o.valid = out_valid_q;
  assign average_ch_o.average = out_avg_q;

  // Sample ring storage
  mavg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_READ),
    .waddr_i (ptr_q),
    .wdata_i (sample_q),
    .re_i    (in_xfer && (window_q != '0)),
    .raddr_i (ptr_q),
    .rdata_o (ring_rdata)
  );

  // Swap the oldest entry for the new sample in the running sum
  always_comb begin
    old_sample   = ring_vld_q[ptr_q] ? ring_rdata : '0;
    sum_new      = sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
    ptr_inc      = WIN_W'(ptr_q) + WIN_W'(1);
    ptr_wrap_div = ptr_inc > window_q;
    half_win     = DIV_W'(window_q >> 1);
  end

  // Divider requests: the rounded mean, preceded by a pointer modulo after a shrink
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    case (state_q)
      ST_READ: begin
        div_start    = 1'b1;
        div_dividend = ptr_wrap_div ? DIV_W'(ptr_inc) : DIV_W'(sum_new) + half_win;
      end
      ST_PMOD: begin
        div_start    = div_done;
        div_dividend = DIV_W'(sum_q) + half_win;
      end
      default: begin
        div_start    = 1'b0;
        div_dividend = '0;
      end
    endcase
  end

  mavg_div #(
    .DIV_W (DIV_W),
    .DEN_W (WIN_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (window_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Clip a mean that stale entries pushed above the sample range
  assign mean_sat = (div_quo > DIV_W'(SAMPLE_MAX)) ? SAMPLE_MAX : div_quo[SAMPLE_BITS-1:0];

  // Sequencer, filter state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      sum_q       <= '0;
      sample_q    <= '0;
      res_q       <= '0;
      ring_vld_q  <= '0;
      out_valid_q <= 1'b0;
      out_avg_q   <= '0;
    end else begin
      if (out_valid_q && average_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            sample_q <= sample_ch_i.sample;
            if (window_q == '0) begin
              res_q   <= sample_ch_i.sample;
              state_q <= ST_HOLD;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          sum_q             <= sum_new;
          ring_vld_q[ptr_q] <= 1'b1;
          if (ptr_wrap_div) begin
            state_q <= ST_PMOD;
          end else begin
            ptr_q   <= (ptr_inc == window_q) ? '0 : PTR_W'(ptr_inc);
            state_q <= ST_MEAN;
          end
        end
        ST_PMOD: begin
          if (div_done) begin
            ptr_q   <= PTR_W'(div_rem);
            state_q <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          if (div_done) begin
            res_q   <= mean_sat;
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_avg_q   <= res_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
